@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication outside reset
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/plt_pkg.sv @@
`default_nettype none

package plt_pkg;

   localparam int unsigned DEF_MAP_BITS   = 1200;
   localparam int unsigned DEF_INNER_BITS = 400;
   localparam int unsigned DEF_GROUP_BITS = 20;
   localparam int unsigned DEF_WORD_BITS  = 64;

   localparam int unsigned INNER_SECTORS = 20;
   localparam int unsigned OUTER_SECTORS = 40;
   localparam int unsigned SEP_W         = 5;
   localparam logic [SEP_W-1:0] SEP_MAX  = 5'd19;
   localparam int unsigned COUNT_W       = 9;

   localparam int unsigned MAP_W  = 64;
   localparam int unsigned RSP_W  = 16;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DPHI_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DPHI_MAX = 2'd1;

   localparam logic [SEP_W-1:0] DPHI_MIN_RESET = 5'd0;
   localparam logic [SEP_W-1:0] DPHI_MAX_RESET = 5'd10;

   typedef logic [INNER_SECTORS-1:0] fired_type;

   // one finished event's fired sectors, moving from front to back
   typedef struct packed {
      logic      valid;
      fired_type fired;
   } fired_beat_type;

endpackage

`default_nettype wire

@@ hw/rtl/plt_front.sv @@
`default_nettype none

module plt_front #(
   parameter int unsigned MAP_BITS   = plt_pkg::DEF_MAP_BITS,
   parameter int unsigned INNER_BITS = plt_pkg::DEF_INNER_BITS,
   parameter int unsigned GROUP_BITS = plt_pkg::DEF_GROUP_BITS,
   parameter int unsigned WORD_BITS  = plt_pkg::DEF_WORD_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [plt_pkg::MAP_W-1:0]  req_tdata,
   input  wire logic                       req_tlast,
   input  wire logic                       q_full,
   output plt_pkg::fired_beat_type         push
);

   localparam int unsigned BASE_W = $clog2(MAP_BITS + WORD_BITS);

   logic [BASE_W-1:0]                       base_ff, base_in;
   logic [plt_pkg::INNER_SECTORS-1:0]       inner_ff, inner_in, inner_hit, inner_new;
   logic [plt_pkg::OUTER_SECTORS-1:0]       outer_ff, outer_in, outer_hit, outer_new;
   plt_pkg::fired_type                      fired;
   logic                                    active;
   logic                                    accept;
   logic [31:0]                             pos;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign active     = base_ff < BASE_W'(MAP_BITS);

   // map each bit of the beat onto its sector group
   always_comb begin
      inner_hit = '0;
      outer_hit = '0;
      pos       = '0;
      for (int b = 0; b < int'(WORD_BITS); b++) begin
         pos = 32'(base_ff) + 32'(b);
         if (active && req_tdata[b] && pos < 32'(MAP_BITS)) begin
            for (int g = 0; g < int'(plt_pkg::INNER_SECTORS); g++) begin
               if (pos >= 32'(g * GROUP_BITS) && pos < 32'((g + 1) * GROUP_BITS) &&
                   pos < 32'(INNER_BITS)) begin
                  inner_hit[g] = 1'b1;
               end
            end
            for (int g = 0; g < int'(plt_pkg::OUTER_SECTORS); g++) begin
               if (pos >= 32'(INNER_BITS + g * GROUP_BITS) &&
                   pos < 32'(INNER_BITS + (g + 1) * GROUP_BITS)) begin
                  outer_hit[g] = 1'b1;
               end
            end
         end
      end
   end

   assign inner_new = inner_ff | inner_hit;
   assign outer_new = outer_ff | outer_hit;

   // inner sector plus one of its four neighboring outer sectors
   always_comb begin
      for (int i = 0; i < int'(plt_pkg::INNER_SECTORS); i++) begin
         fired[i] = inner_new[i] &
                    (outer_new[(2 * i) % plt_pkg::OUTER_SECTORS] |
                     outer_new[(2 * i + 1) % plt_pkg::OUTER_SECTORS] |
                     outer_new[(2 * i + 2) % plt_pkg::OUTER_SECTORS] |
                     outer_new[(2 * i + 39) % plt_pkg::OUTER_SECTORS]);
      end
   end

   always_comb begin
      base_in  = base_ff;
      inner_in = inner_ff;
      outer_in = outer_ff;
      if (accept) begin
         if (req_tlast) begin
            base_in  = '0;
            inner_in = '0;
            outer_in = '0;
         end else begin
            inner_in = inner_new;
            outer_in = outer_new;
            if (active) begin
               base_in = base_ff + BASE_W'(WORD_BITS);
            end
         end
      end
   end

   assign push.valid = accept && req_tlast;
   assign push.fired = fired;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         inner_ff <= '0;
         outer_ff <= '0;
      end else begin
         base_ff  <= base_in;
         inner_ff <= inner_in;
         outer_ff <= outer_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/plt_queue.sv @@
`default_nettype none

module plt_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire plt_pkg::fired_beat_type  push,
   output logic                          q_full,
   input  wire logic                     pop,
   output plt_pkg::fired_beat_type       head
);

   localparam int unsigned DEPTH = plt_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   plt_pkg::fired_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign q_full     = count_ff == CNT_W'(DEPTH);
   assign do_push    = push.valid && !q_full;
   assign do_pop     = pop && count_ff != '0;
   assign head.valid = count_ff != '0;
   assign head.fired = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.fired;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/plt_back.sv @@
`default_nettype none

module plt_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [plt_pkg::SEP_W-1:0]     dphi_min,
   input  wire logic [plt_pkg::SEP_W-1:0]     dphi_max,
   input  wire plt_pkg::fired_beat_type       head,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic                               trigger_fired,
   output logic [plt_pkg::COUNT_W-1:0]        pair_count
);

   localparam int unsigned NSEC   = plt_pkg::INNER_SECTORS;
   localparam int unsigned CHUNK  = 5;
   localparam int unsigned NCHUNK = NSEC / CHUNK;
   localparam int unsigned SEPC_W = $clog2(NSEC + 1);
   localparam int unsigned PART_W = $clog2(NSEC * CHUNK + 1);

   function automatic logic [2:0] count5(input logic [CHUNK-1:0] v);
      logic [2:0] c;
      c = '0;
      for (int k = 0; k < int'(CHUNK); k++) begin
         c = c + 3'(v[k]);
      end
      return c;
   endfunction

   logic [plt_pkg::SEP_W-1:0] lo, hi;
   logic [SEPC_W-1:0]         sep_cnt [NSEC];
   logic [SEPC_W-1:0]         sep_ff  [NSEC];
   logic [PART_W-1:0]         part_in [NCHUNK];
   logic [PART_W-1:0]         part_ff [NCHUNK];
   logic [plt_pkg::COUNT_W-1:0] total;
   logic [plt_pkg::COUNT_W-1:0] count_ff;
   logic                      s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic                      out_ready, s2_ready, s1_ready;
   logic [NSEC-1:0]           both;

   assign lo = (dphi_min > plt_pkg::SEP_MAX) ? plt_pkg::SEP_MAX : dphi_min;
   assign hi = (dphi_max > plt_pkg::SEP_MAX) ? plt_pkg::SEP_MAX : dphi_max;

   assign out_ready = !out_valid_ff || rsp_tready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop       = head.valid && s1_ready;

   // per separation: sectors i and i+d both fired
   always_comb begin
      both = '0;
      for (int d = 0; d < int'(NSEC); d++) begin
         for (int i = 0; i < int'(NSEC); i++) begin
            both[i] = head.fired[i] & head.fired[(i + d) % NSEC];
         end
         sep_cnt[d] = '0;
         if (plt_pkg::SEP_W'(d) >= lo && plt_pkg::SEP_W'(d) <= hi) begin
            for (int c = 0; c < int'(NCHUNK); c++) begin
               sep_cnt[d] = sep_cnt[d] + SEPC_W'(count5(both[c*CHUNK +: CHUNK]));
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < int'(NCHUNK); c++) begin
         part_in[c] = '0;
         for (int k = 0; k < int'(CHUNK); k++) begin
            part_in[c] = part_in[c] + PART_W'(sep_ff[c*CHUNK + k]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int c = 0; c < int'(NCHUNK); c++) begin
         total = total + plt_pkg::COUNT_W'(part_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         sep_ff <= sep_cnt;
      end
      if (s2_ready) begin
         part_ff <= part_in;
      end
      if (out_ready) begin
         count_ff <= total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= head.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign pair_count    = count_ff;
   assign trigger_fired = count_ff != '0;

endmodule

`default_nettype wire

@@ hw/rtl/pixel_layer_topology_trigger_core.sv @@
// the last map beat's result passes the event queue, then the s1, s2 and out registers
// throughput: one map beat per cycle while the queue is not full, one result per event, back to back
// rate is set by the front accumulator and a three-stage pair-count pipeline
// reset (synchronous, high) clears sector flags, queue and pipeline,
// and sets dphi_min to 0 and dphi_max to 10
`default_nettype none

`include "assert_macros.svh"

module pixel_layer_topology_trigger_core #(
   parameter int unsigned MAP_BITS   = plt_pkg::DEF_MAP_BITS,
   parameter int unsigned INNER_BITS = plt_pkg::DEF_INNER_BITS,
   parameter int unsigned GROUP_BITS = plt_pkg::DEF_GROUP_BITS,
   parameter int unsigned WORD_BITS  = plt_pkg::DEF_WORD_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [plt_pkg::MAP_W-1:0]       req_tdata,  // [63:0] map_word
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [plt_pkg::RSP_W-1:0]            rsp_tdata,  // [0] trigger_fired, [9:1] pair_count
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [plt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [plt_pkg::SEP_W-1:0]       csr_data
);

   plt_pkg::fired_beat_type          push;
   plt_pkg::fired_beat_type          head;
   logic                             q_full;
   logic                             pop;
   logic                             trigger_fired;
   logic [plt_pkg::COUNT_W-1:0]      pair_count;
   logic [plt_pkg::SEP_W-1:0]        dphi_min_ff;
   logic [plt_pkg::SEP_W-1:0]        dphi_max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dphi_min_ff <= plt_pkg::DPHI_MIN_RESET;
         dphi_max_ff <= plt_pkg::DPHI_MAX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            plt_pkg::CSR_DPHI_MIN: dphi_min_ff <= csr_data;
            plt_pkg::CSR_DPHI_MAX: dphi_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   plt_front #(
      .MAP_BITS   (MAP_BITS),
      .INNER_BITS (INNER_BITS),
      .GROUP_BITS (GROUP_BITS),
      .WORD_BITS  (WORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   plt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .q_full (q_full),
      .pop    (pop),
      .head   (head)
   );

   plt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .dphi_min      (dphi_min_ff),
      .dphi_max      (dphi_max_ff),
      .head          (head),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .trigger_fired (trigger_fired),
      .pair_count    (pair_count)
   );

   assign rsp_tdata = {{(plt_pkg::RSP_W - plt_pkg::COUNT_W - 1){1'b0}}, pair_count, trigger_fired};

   `ASSERT_IMPLY(a_fired_matches_count, clock, reset, rsp_tvalid, trigger_fired == (pair_count != '0))
   `ASSERT_IMPLY(a_count_in_range, clock, reset, rsp_tvalid, pair_count <= 9'd400)
   `ASSERT_IMPLY(a_no_push_when_full, clock, reset, push.valid, !q_full)
   `ASSERT_NEXT(a_reset_clears_output, clock, reset, !rsp_tvalid)

endmodule

`default_nettype wire

@@ bench/pixel_layer_topology_trigger_core_test.sv @@
`timescale 1ns / 100ps

module pixel_layer_topology_trigger_core_test;
   import plt_pkg::*;

   localparam int WORD_W      = DEF_WORD_BITS;
   localparam int MAP_WORDS   = (DEF_MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int PADDED_BITS = MAP_WORDS * WORD_W;
   localparam int PAD_W       = PADDED_BITS - DEF_MAP_BITS;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int SEGMENT_BEATS = 160;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              is_last;
   } map_beat_type;

   typedef struct packed {
      logic               fired;
      logic [COUNT_W-1:0] pairs;
   } tally_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [MAP_W-1:0]     req_tdata = '0;  // [63:0] map_word
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;       // [0] trigger_fired, [9:1] pair_count
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DPHI_MIN;
   logic [SEP_W-1:0]     csr_data = '0;

   pixel_layer_topology_trigger_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // stimulus and expectation stores
   map_beat_type pending_beats[$];
   tally_type    expected_tallies[$];

   // predictor copy of the block
   logic [SEP_W-1:0]         min_sep_setting;
   logic [SEP_W-1:0]         max_sep_setting;
   int                       map_word_index;
   logic [INNER_SECTORS-1:0] inner_hits;
   logic [OUTER_SECTORS-1:0] outer_hits;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  rsp_hold_left = 0;
   bit  beat_taken = 1'b0;
   int  beats_queued = 0;
   int  beats_taken = 0;
   int  events_queued = 0;
   int  results_seen = 0;
   int  results_fired = 0;
   int  largest_count = 0;
   int  settings_used = 1;
   int  mismatches = 0;
   int  quiet_cycles = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   // fold one map beat into the sector flags; the last beat yields a tally
   task automatic take_map_beat(input logic [WORD_W-1:0] word, input logic is_last);
      logic [INNER_SECTORS-1:0] fired;
      tally_type                tally;
      int                       pos, lo, hi, pairs;
      if (map_word_index < MAP_WORDS) begin
         for (int b = 0; b < WORD_W; b++) begin
            pos = map_word_index * WORD_W + b;
            if (pos < DEF_MAP_BITS && word[b]) begin
               if (pos < DEF_INNER_BITS)
                  inner_hits[pos / DEF_GROUP_BITS] = 1'b1;
               else
                  outer_hits[(pos - DEF_INNER_BITS) / DEF_GROUP_BITS] = 1'b1;
            end
         end
         map_word_index++;
      end
      if (is_last) begin
         for (int i = 0; i < INNER_SECTORS; i++) begin
            fired[i] = inner_hits[i] & (outer_hits[(2 * i) % OUTER_SECTORS] |
                                        outer_hits[(2 * i + 1) % OUTER_SECTORS] |
                                        outer_hits[(2 * i + 2) % OUTER_SECTORS] |
                                        outer_hits[(2 * i + OUTER_SECTORS - 1) % OUTER_SECTORS]);
         end
         lo = int'((min_sep_setting > SEP_MAX) ? SEP_MAX : min_sep_setting);
         hi = int'((max_sep_setting > SEP_MAX) ? SEP_MAX : max_sep_setting);
         pairs = 0;
         for (int d = lo; d <= hi; d++) begin
            for (int i = 0; i < INNER_SECTORS; i++) begin
               if (fired[i] && fired[(i + d) % INNER_SECTORS])
                  pairs++;
            end
         end
         tally.fired = (pairs != 0);
         tally.pairs = pairs[COUNT_W-1:0];
         expected_tallies.insert(expected_tallies.size(), tally);
         map_word_index = 0;
         inner_hits = '0;
         outer_hits = '0;
      end
   endtask

   // sender: holds a beat until it is taken, then offers the next or idles
   always @(negedge clock) begin : drive_map
      map_beat_type offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beat_taken) begin
         beat_taken = 1'b0;
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer = pending_beats.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= offer.word;
            req_tlast <= offer.is_last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watch
      tally_type want;
      bit        moved;
      if (reset) begin
         min_sep_setting = DPHI_MIN_RESET;
         max_sep_setting = DPHI_MAX_RESET;
         map_word_index = 0;
         inner_hits = '0;
         outer_hits = '0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_DPHI_MIN: min_sep_setting = csr_data;
               CSR_DPHI_MAX: max_sep_setting = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            if (expected_tallies.size() == 0) begin
               report_mismatch($sformatf("result beat %h with nothing expected", rsp_tdata));
            end else begin
               want = expected_tallies.pop_front();
               if (rsp_tdata[0] !== want.fired)
                  report_mismatch($sformatf("trigger_fired %b, expected %b",
                                            rsp_tdata[0], want.fired));
               if (rsp_tdata[COUNT_W:1] !== want.pairs)
                  report_mismatch($sformatf("pair_count %0d, expected %0d",
                                            rsp_tdata[COUNT_W:1], want.pairs));
               if (rsp_tdata[RSP_W-1:COUNT_W+1] !== '0)
                  report_mismatch($sformatf("padding bits %b not zero",
                                            rsp_tdata[RSP_W-1:COUNT_W+1]));
               if (want.fired)
                  results_fired++;
               if (want.pairs > largest_count)
                  largest_count = want.pairs;
            end
         end
         // predict after the result check so a same-edge push never pairs up early
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            beat_taken = 1'b1;
            beats_taken++;
            take_map_beat(req_tdata, req_tlast);
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic queue_beat(input logic [WORD_W-1:0] word, input logic is_last);
      map_beat_type beat;
      beat.word = word;
      beat.is_last = is_last;
      pending_beats.insert(pending_beats.size(), beat);
      beats_queued++;
      if (is_last)
         events_queued++;
   endtask

   // one event: sector-shaped map content, or pure noise words
   task automatic queue_event(input int len, input bit noisy);
      logic [PADDED_BITS-1:0] map_bits;
      logic [WORD_W-1:0]      word;
      int                     inner_pct, outer_pct;
      map_bits = '0;
      inner_pct = $urandom_range(0, 4) * 25;
      outer_pct = $urandom_range(0, 4) * 25;
      for (int g = 0; g < INNER_SECTORS; g++) begin
         if ($urandom_range(99) < inner_pct)
            map_bits[g * DEF_GROUP_BITS + $urandom_range(DEF_GROUP_BITS - 1)] = 1'b1;
      end
      for (int g = 0; g < OUTER_SECTORS; g++) begin
         if ($urandom_range(99) < outer_pct)
            map_bits[DEF_INNER_BITS + g * DEF_GROUP_BITS +
                     $urandom_range(DEF_GROUP_BITS - 1)] = 1'b1;
      end
      // bits past the map end should never matter
      map_bits[PADDED_BITS-1:DEF_MAP_BITS] = PAD_W'($urandom);
      for (int k = 0; k < len; k++) begin
         if (noisy || k >= MAP_WORDS)
            word = {$urandom, $urandom};
         else
            word = map_bits[k * WORD_W +: WORD_W];
         queue_beat(word, k == len - 1);
      end
   endtask

   task automatic drain;
      while (beats_taken != beats_queued || expected_tallies.size() != 0)
         @(negedge clock);
      // non-last beats give no result, so leave room for the pipeline to settle
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [SEP_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_separations(input logic [SEP_W-1:0] lo, input logic [SEP_W-1:0] hi);
      write_reg(CSR_DPHI_MIN, lo);
      write_reg(CSR_DPHI_MAX, hi);
      @(negedge clock) csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin
      logic [SEP_W-1:0] lo_choice[9];
      logic [SEP_W-1:0] hi_choice[9];
      int               seg_start, r, len;

      lo_choice = '{5'd0, 5'd19, 5'd0, 5'd19, 5'd31, 5'd3, 5'd7, 5'd0, 5'd0};
      hi_choice = '{5'd19, 5'd19, 5'd0, 5'd0, 5'd31, 5'd25, 5'd5, 5'd0, 5'd0};
      lo_choice[7] = SEP_W'($urandom_range(0, 31));
      hi_choice[7] = SEP_W'($urandom_range(0, 31));
      lo_choice[8] = SEP_W'($urandom_range(0, 31));
      hi_choice[8] = SEP_W'($urandom_range(0, 31));

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // directed events under the reset separations
      send_idle_pct = 36;
      recv_idle_pct = 49;
      queue_beat('0, 1'b1);
      queue_beat('1, 1'b1);
      // full map of ones, then one beat past the end as the last
      for (int k = 0; k <= MAP_WORDS; k++)
         queue_beat('1, k == MAP_WORDS);
      queue_beat({1'b1, {(WORD_W-1){1'b0}}}, 1'b1);
      queue_beat({{(WORD_W-1){1'b0}}, 1'b1}, 1'b1);
      drain();

      for (int seg = 0; seg < 9; seg++) begin
         set_separations(lo_choice[seg], hi_choice[seg]);
         send_idle_pct = (seg < 3) ? 36 : (seg < 6) ? 49 : 0;
         recv_idle_pct = (seg < 3) ? 49 : (seg < 6) ? 36 : 0;
         seg_start = beats_queued;
         if (seg == 1 || seg == 7) begin
            // short events back to back so results pile up behind the hold-off
            for (int e = 0; e < 40; e++)
               queue_event($urandom_range(1, 3), 1'b0);
            rsp_hold_left = HOLD_CYCLES;
         end
         while (beats_queued - seg_start < SEGMENT_BEATS) begin
            r = $urandom_range(99);
            if (r < 55)
               queue_event(MAP_WORDS, 1'b0);
            else if (r < 72)
               queue_event($urandom_range(1, MAP_WORDS - 1), 1'b0);
            else if (r < 87)
               queue_event($urandom_range(MAP_WORDS + 1, MAP_WORDS + 5), 1'b0);
            else begin
               len = $urandom_range(1, MAP_WORDS + 5);
               queue_event(len, 1'b1);
            end
         end
         drain();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d map beats in %0d events over %0d separation settings",
               beats_taken, events_queued, settings_used);
      $display("checked %0d results, %0d fired, largest pair count %0d",
               results_seen, results_fired, largest_count);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/plt_pkg.sv
hw/rtl/plt_front.sv
hw/rtl/plt_queue.sv
hw/rtl/plt_back.sv
hw/rtl/pixel_layer_topology_trigger_core.sv
bench/pixel_layer_topology_trigger_core_test.sv
